/* design/lfmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower mode controller package
// Shared widths, register map, mode codes, arithmetic constants and the
// command, status and configuration structures of the controller.
// ----------------------------------------------------------------------------
package lfmc_pkg;

  // Sensor front end.
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_SENSORS = 8;

  // Field widths.
  localparam int THR_W   = 10;
  localparam int SPEED_W = 12;
  localparam int HOLD_W  = 4;
  localparam int MODE_W  = 3;
  localparam int SCALE_W = 11;
  localparam int WHEEL_W = 13;

  // Threshold compares run at the wider of the sample and threshold widths.
  localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  // Sum of up to eight excess values.
  localparam int EXC_W  = CMP_W + 3;
  // Zone strength: count times one hundred plus the average of two samples.
  localparam int STR_W  = SAMPLE_BITS + 2;
  localparam int STRX_W = STR_W + 1;

  // Configuration port.
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LINE_THR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NOISE_THR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CRUISE_SPD = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TOP_SPD    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_JUNC_HOLD  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CROSS_HOLD = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TURN_HOLD  = 3'd6;

  // Drive modes.
  localparam logic [MODE_W-1:0] MODE_STRAIGHT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TLEFT    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TRIGHT   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CROSS    = 3'd6;

  // Zone strength weighting and decision margins.
  localparam logic [STR_W-1:0]  ZONE_WEIGHT   = STR_W'(100);
  localparam logic [STRX_W-1:0] LR_MARGIN     = STRX_W'(50);
  localparam logic [STRX_W-1:0] CENTER_MARGIN = STRX_W'(20);

  // Speed scale: 819 + floor(excess * 64 / 125), saturating at 1536.
  // Excess values of 1403 and above saturate; below that the quotient is
  // taken by a reciprocal multiply, exact over the whole range.
  localparam int                 EXC_LIN_W          = 11;
  localparam logic [EXC_W-1:0]   EXC_CLAMP          = EXC_W'(1403);
  localparam int                 SCALE_RECIP_W      = 18;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP  = 18'd134218;
  localparam int                 SCALE_RECIP_SHIFT  = 18;
  localparam int                 SCALE_PROD_W       = EXC_LIN_W + SCALE_RECIP_W;
  localparam logic [SCALE_W-1:0] SCALE_MIN          = 11'd819;
  localparam logic [SCALE_W-1:0] SCALE_MAX          = 11'd1536;

  // Wheel lanes: product, reduction shift, optional divide by five.
  localparam int                 PROD_W        = SPEED_W + SCALE_W;
  localparam int                 RED_W         = 16;
  localparam int                 COARSE_SHIFT  = 10;
  localparam int                 FINE_SHIFT    = 1;
  localparam int                 DIV5_RECIP_W  = 16;
  localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 16'd52429;
  localparam int                 DIV5_SHIFT    = 18;
  localparam int                 DIV5_PROD_W   = RED_W + DIV5_RECIP_W;
  localparam logic [SCALE_W-1:0] MUL_ONE       = 11'd1;
  localparam logic [SCALE_W-1:0] MUL_SEARCH    = 11'd7;
  localparam logic [SCALE_W-1:0] MUL_TURN      = 11'd18;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [THR_W-1:0]   line_thr;
    logic [THR_W-1:0]   noise_thr;
    logic [SPEED_W-1:0] cruise_spd;
    logic [SPEED_W-1:0] top_spd;
    logic [HOLD_W-1:0]  junction_hold;
    logic [HOLD_W-1:0]  crossroad_hold;
    logic [HOLD_W-1:0]  turn_hold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    line_thr:       10'd300,
    noise_thr:      10'd200,
    cruise_spd:     12'd2048,
    top_spd:        12'd2560,
    junction_hold:  4'd5,
    crossroad_hold: 4'd10,
    turn_hold:      4'd3
  };

  // Stage strobes from the controller.
  typedef struct packed {
    logic load;
    logic zone_en;
    logic decide_en;
    logic mul_en;
    logic div_en;
    logic fin_en;
  } dp_cmd_t;

  // Datapath status towards the controller.
  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // Operation for one wheel lane.
  typedef struct packed {
    logic [SPEED_W-1:0] a;
    logic [SCALE_W-1:0] c;
    logic               coarse;
    logic               div5;
    logic               neg;
    logic               zero;
  } wheel_op_t;

endpackage

/* design/lfmc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower configuration registers
// APB-style register bank holding thresholds, speeds and hold counts.
// ----------------------------------------------------------------------------
module lfmc_regs import lfmc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t                 cfg_q, cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Write decode; an address beyond the register list is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_LINE_THR:   cfg_d.line_thr       = pwdata[THR_W-1:0];
        REG_NOISE_THR:  cfg_d.noise_thr      = pwdata[THR_W-1:0];
        REG_CRUISE_SPD: cfg_d.cruise_spd     = pwdata[SPEED_W-1:0];
        REG_TOP_SPD:    cfg_d.top_spd        = pwdata[SPEED_W-1:0];
        REG_JUNC_HOLD:  cfg_d.junction_hold  = pwdata[HOLD_W-1:0];
        REG_CROSS_HOLD: cfg_d.crossroad_hold = pwdata[HOLD_W-1:0];
        REG_TURN_HOLD:  cfg_d.turn_hold      = pwdata[HOLD_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      REG_LINE_THR:   prdata = PDATA_W'(cfg_q.line_thr);
      REG_NOISE_THR:  prdata = PDATA_W'(cfg_q.noise_thr);
      REG_CRUISE_SPD: prdata = PDATA_W'(cfg_q.cruise_spd);
      REG_TOP_SPD:    prdata = PDATA_W'(cfg_q.top_spd);
      REG_JUNC_HOLD:  prdata = PDATA_W'(cfg_q.junction_hold);
      REG_CROSS_HOLD: prdata = PDATA_W'(cfg_q.crossroad_hold);
      REG_TURN_HOLD:  prdata = PDATA_W'(cfg_q.turn_hold);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* design/lfmc_wheel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower wheel lane
// Two-stage arithmetic for one wheel: the product, then a shift and an
// optional divide by five by reciprocal multiply, then clamp and sign.
// ----------------------------------------------------------------------------
module lfmc_wheel import lfmc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      mul_en_i,
  input  logic                      div_en_i,
  input  wheel_op_t                 op_i,
  input  logic [SPEED_W-1:0]        top_spd_i,
  output logic signed [WHEEL_W-1:0] wheel_o
);

  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [RED_W-1:0]       red;
  logic [DIV5_PROD_W-1:0] div_prod;
  logic [RED_W-1:0]       quot_q, quot_d;
  logic [SPEED_W-1:0]     mag;
  logic [WHEEL_W-1:0]     mag_ext;

  // First stage: speed operand times scale or small constant.
  assign prod_d = PROD_W'(op_i.a) * PROD_W'(op_i.c);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Second stage: drop ten fraction bits or halve, then divide by five.
  // The halved case only ever carries small constants, so the product
  // fits the reduced width.
  assign red      = op_i.coarse ? RED_W'(prod_q >> COARSE_SHIFT)
                                : RED_W'(prod_q >> FINE_SHIFT);
  assign div_prod = DIV5_PROD_W'(red) * DIV5_PROD_W'(DIV5_RECIP);
  assign quot_d   = op_i.div5 ? RED_W'(div_prod >> DIV5_SHIFT) : red;

  always_ff @(posedge clk_i) begin
    if (div_en_i) begin
      quot_q <= quot_d;
    end
  end

  // Clamp to the maximum speed; the search mode negates the clamped value.
  assign mag     = (quot_q > RED_W'(top_spd_i)) ? top_spd_i : quot_q[SPEED_W-1:0];
  assign mag_ext = {1'b0, mag};

  always_comb begin
    if (op_i.zero) begin
      wheel_o = '0;
    end else if (op_i.neg) begin
      wheel_o = -$signed(mag_ext);
    end else begin
      wheel_o = $signed(mag_ext);
    end
  end

endmodule

/* design/lfmc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower datapath
// Sample register, zone analysis, mode and timer state, speed scale and the
// two wheel lanes, with the result register.
// ----------------------------------------------------------------------------
module lfmc_datapath import lfmc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o,
  input  cfg_t                      cfg_i,
  input  logic [SAMPLE_BITS-1:0]    sample_i [NUM_SENSORS],
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic signed [WHEEL_W-1:0] left_wheel_o,
  output logic signed [WHEEL_W-1:0] right_wheel_o,
  output logic [MODE_W-1:0]         drive_mode_o,
  output logic [SCALE_W-1:0]        speed_scale_o
);

  // Sample register.
  logic [SAMPLE_BITS-1:0] samp_q [NUM_SENSORS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      samp_q <= sample_i;
    end
  end

  // Zone analysis.
  logic [CMP_W-1:0]       samp_ext [NUM_SENSORS];
  logic [CMP_W-1:0]       lt_ext, nt_ext;
  logic [NUM_SENSORS-1:0] on_line, below_line, hit;
  logic [EXC_W-1:0]       exc_d, exc_q;
  logic [1:0]             cnt_r, cnt_l;
  logic [2:0]             cnt_c;
  logic [SAMPLE_BITS:0]   pair_r, pair_c, pair_l;
  logic [STR_W-1:0]       ls_d, rs_d, cs_d, ls_q, rs_q, cs_q;
  logic                   tl_d, tr_d, cr_d, tl_q, tr_q, cr_q;

  assign lt_ext = CMP_W'(cfg_i.line_thr);
  assign nt_ext = CMP_W'(cfg_i.noise_thr);

  always_comb begin
    exc_d = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      samp_ext[i]   = CMP_W'(samp_q[i]);
      on_line[i]    = samp_ext[i] > lt_ext;
      below_line[i] = samp_ext[i] < lt_ext;
      hit[i]        = on_line[i] && (samp_ext[i] > nt_ext);
      if (hit[i]) begin
        exc_d = exc_d + EXC_W'(samp_ext[i] - lt_ext);
      end
    end
  end

  assign cnt_r = 2'(hit[0]) + 2'(hit[1]);
  assign cnt_l = 2'(hit[6]) + 2'(hit[7]);
  assign cnt_c = 3'(hit[2]) + 3'(hit[3]) + 3'(hit[4]) + 3'(hit[5]);

  // Junction patterns.
  assign tl_d = (cnt_c >= 3'd2) && (cnt_l == 2'd2) && (cnt_r == 2'd0) &&
                below_line[5] && on_line[6] && on_line[7];
  assign tr_d = (cnt_c >= 3'd2) && (cnt_r == 2'd2) && (cnt_l == 2'd0) &&
                on_line[0] && on_line[1] && on_line[2] &&
                below_line[5] && below_line[6] && below_line[7];
  assign cr_d = (cnt_c == 3'd4) && (cnt_l == 2'd2) && (cnt_r == 2'd2);

  // Zone strengths.
  assign pair_r = {1'b0, samp_q[0]} + {1'b0, samp_q[1]};
  assign pair_c = {1'b0, samp_q[3]} + {1'b0, samp_q[4]};
  assign pair_l = {1'b0, samp_q[6]} + {1'b0, samp_q[7]};
  assign rs_d   = STR_W'(cnt_r) * ZONE_WEIGHT + STR_W'(pair_r[SAMPLE_BITS:1]);
  assign cs_d   = STR_W'(cnt_c) * ZONE_WEIGHT + STR_W'(pair_c[SAMPLE_BITS:1]);
  assign ls_d   = STR_W'(cnt_l) * ZONE_WEIGHT + STR_W'(pair_l[SAMPLE_BITS:1]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.zone_en) begin
      exc_q <= exc_d;
      ls_q  <= ls_d;
      rs_q  <= rs_d;
      cs_q  <= cs_d;
      tl_q  <= tl_d;
      tr_q  <= tr_d;
      cr_q  <= cr_d;
    end
  end

  // Mode decision with junction and turn hold timers.
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [HOLD_W-1:0] jt_q, jt_d, tt_q, tt_d;
  logic [STRX_W-1:0] ls_x, rs_x, cs_x;
  logic              left_pick, right_pick, straight_pick;

  assign ls_x = {1'b0, ls_q};
  assign rs_x = {1'b0, rs_q};
  assign cs_x = {1'b0, cs_q};

  assign left_pick     = (ls_x > rs_x + LR_MARGIN) && (ls_x > cs_x + CENTER_MARGIN);
  assign right_pick    = (rs_x > ls_x + LR_MARGIN) && (rs_x > cs_x + CENTER_MARGIN);
  assign straight_pick = (cs_q > ls_q) && (cs_q > rs_q);

  always_comb begin
    mode_d = mode_q;
    jt_d   = jt_q;
    tt_d   = tt_q;
    if (tl_q && (jt_q == '0)) begin
      mode_d = MODE_TLEFT;
      jt_d   = cfg_i.junction_hold;
    end else if (tr_q && (jt_q == '0)) begin
      mode_d = MODE_TRIGHT;
      jt_d   = cfg_i.junction_hold;
    end else if (cr_q && (jt_q == '0)) begin
      mode_d = MODE_CROSS;
      jt_d   = cfg_i.crossroad_hold;
    end else if (jt_q != '0) begin
      jt_d = jt_q - HOLD_W'(1);
    end else if (tt_q != '0) begin
      tt_d = tt_q - HOLD_W'(1);
    end else if (left_pick) begin
      mode_d = MODE_LEFT;
      tt_d   = cfg_i.turn_hold;
    end else if (right_pick) begin
      mode_d = MODE_RIGHT;
      tt_d   = cfg_i.turn_hold;
    end else if (straight_pick) begin
      mode_d = MODE_STRAIGHT;
    end else begin
      mode_d = MODE_SEARCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
      jt_q   <= '0;
      tt_q   <= '0;
    end else if (cmd_i.decide_en) begin
      mode_q <= mode_d;
      jt_q   <= jt_d;
      tt_q   <= tt_d;
    end
  end

  // Speed scale from the line excess, saturating at its upper bound.
  logic [EXC_LIN_W-1:0]    exc_lin;
  logic [SCALE_PROD_W-1:0] scale_prod;
  logic [SCALE_W-1:0]      scale_q, scale_d;

  assign exc_lin    = EXC_LIN_W'(exc_q);
  assign scale_prod = SCALE_PROD_W'(exc_lin) * SCALE_PROD_W'(SCALE_RECIP);
  assign scale_d    = (exc_q >= EXC_CLAMP) ? SCALE_MAX
                    : SCALE_MIN + SCALE_W'(scale_prod >> SCALE_RECIP_SHIFT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide_en) begin
      scale_q <= scale_d;
    end
  end

  // Per-mode lane operations.
  wheel_op_t lop, rop;

  always_comb begin
    lop.a      = cfg_i.cruise_spd;
    lop.c      = scale_q;
    lop.coarse = 1'b1;
    lop.div5   = 1'b0;
    lop.neg    = 1'b0;
    lop.zero   = 1'b0;
    rop        = lop;
    case (mode_q)
      MODE_STRAIGHT: begin
        rop = lop;
      end
      MODE_RIGHT: begin
        lop.a    = cfg_i.top_spd;
        rop.div5 = 1'b1;
      end
      MODE_LEFT: begin
        lop.div5 = 1'b1;
        rop.a    = cfg_i.top_spd;
      end
      MODE_TLEFT: begin
        lop.c      = MUL_ONE;
        lop.coarse = 1'b0;
        lop.div5   = 1'b1;
        rop.c      = MUL_TURN;
        rop.coarse = 1'b0;
        rop.div5   = 1'b1;
      end
      MODE_TRIGHT: begin
        lop.c      = MUL_TURN;
        lop.coarse = 1'b0;
        lop.div5   = 1'b1;
        rop.c      = MUL_ONE;
        rop.coarse = 1'b0;
        rop.div5   = 1'b1;
      end
      MODE_CROSS: begin
        lop.zero = 1'b1;
        rop.zero = 1'b1;
      end
      default: begin
        // Search: spin in place at seven tenths of the base speed.
        lop.c      = MUL_SEARCH;
        lop.coarse = 1'b0;
        lop.div5   = 1'b1;
        rop.c      = MUL_SEARCH;
        rop.coarse = 1'b0;
        rop.div5   = 1'b1;
        rop.neg    = 1'b1;
      end
    endcase
  end

  // Wheel lanes.
  logic signed [WHEEL_W-1:0] wheel_l, wheel_r;

  lfmc_wheel u_wheel_left (
    .clk_i     (clk_i),
    .mul_en_i  (cmd_i.mul_en),
    .div_en_i  (cmd_i.div_en),
    .op_i      (lop),
    .top_spd_i (cfg_i.top_spd),
    .wheel_o   (wheel_l)
  );

  lfmc_wheel u_wheel_right (
    .clk_i     (clk_i),
    .mul_en_i  (cmd_i.mul_en),
    .div_en_i  (cmd_i.div_en),
    .op_i      (rop),
    .top_spd_i (cfg_i.top_spd),
    .wheel_o   (wheel_r)
  );

  // Result register.
  logic                      out_valid_q, out_valid_d;
  logic signed [WHEEL_W-1:0] left_q, right_q;
  logic [MODE_W-1:0]         dmode_q;
  logic [SCALE_W-1:0]        oscale_q;

  always_comb begin
    if (cmd_i.fin_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en) begin
      left_q   <= wheel_l;
      right_q  <= wheel_r;
      dmode_q  <= mode_q;
      oscale_q <= scale_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign left_wheel_o      = left_q;
  assign right_wheel_o     = right_q;
  assign drive_mode_o      = dmode_q;
  assign speed_scale_o     = oscale_q;
  assign status_o.out_full = out_valid_q;

  // A running junction timer belongs to a junction mode.
  a_junction_timer_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (jt_q != '0) |-> ((mode_q == MODE_TLEFT) || (mode_q == MODE_TRIGHT) ||
                      (mode_q == MODE_CROSS)))
    else $error("junction timer running outside a junction mode");

  // A running turn timer belongs to a turn or to a junction that overrode it.
  a_turn_timer_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tt_q != '0) |-> ((mode_q == MODE_LEFT) || (mode_q == MODE_RIGHT) ||
                      (mode_q == MODE_TLEFT) || (mode_q == MODE_TRIGHT) ||
                      (mode_q == MODE_CROSS)))
    else $error("turn timer running in a mode that cannot hold it");

  // A delivered speed scale lies within its saturation limits.
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((oscale_q >= SCALE_MIN) && (oscale_q <= SCALE_MAX)))
    else $error("speed scale outside its range");

endmodule

/* design/lfmc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower controller
// Sequences one control tick through zone analysis, mode decision, the two
// lane stages and the result register.
// ----------------------------------------------------------------------------
module lfmc_ctrl import lfmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ZONE   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and stage strobes.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ZONE;
        end
      end
      ST_ZONE: begin
        cmd_o.zone_en = 1'b1;
        state_d       = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide_en = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        // Wait here while the previous result is still held.
        if (!status_i.out_full || out_ready_i) begin
          cmd_o.fin_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Writing a result always frees the input side on the next cycle.
  a_fin_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_en |=> in_ready_o)
    else $error("input not ready after the result was written");

endmodule

/* design/line_follower_mode_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower mode controller
// Per control tick: zone counts over eight reflectance samples, junction and
// turn handling with hold timers, speed scaling and wheel speed commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   sample_0_i .. sample_7_i
// result    out        out_valid_o / out_ready_i left/right_wheel_o, drive_mode_o,
//                                                speed_scale_o
// config    in         psel, penable, pwrite     paddr, pwdata, prdata
//
// A transaction on the input is worked through five stages (zone analysis,
// mode decision, lane multiply, lane divide, result write) in that order;
// the input is ready again only after the result write, so a new transaction
// is not taken before the last one is through.
// The result register lets the next transaction be accepted and processed
// while a result waits; the final stage holds until that result is taken.
// Reset is asynchronous and active low; it restores the register defaults,
// the search mode and cleared hold timers.
// ----------------------------------------------------------------------------
module line_follower_mode_controller_core import lfmc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [SAMPLE_BITS-1:0]    sample_0_i,
  input  logic [SAMPLE_BITS-1:0]    sample_1_i,
  input  logic [SAMPLE_BITS-1:0]    sample_2_i,
  input  logic [SAMPLE_BITS-1:0]    sample_3_i,
  input  logic [SAMPLE_BITS-1:0]    sample_4_i,
  input  logic [SAMPLE_BITS-1:0]    sample_5_i,
  input  logic [SAMPLE_BITS-1:0]    sample_6_i,
  input  logic [SAMPLE_BITS-1:0]    sample_7_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [WHEEL_W-1:0] left_wheel_o,
  output logic signed [WHEEL_W-1:0] right_wheel_o,
  output logic [MODE_W-1:0]         drive_mode_o,
  output logic [SCALE_W-1:0]        speed_scale_o
);

  cfg_t                   cfg;
  dp_cmd_t                cmd;
  dp_status_t             status;
  logic [SAMPLE_BITS-1:0] samples [NUM_SENSORS];

  // Gather the sensor ports, rightmost first.
  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  lfmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfmc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_i         (cfg),
    .sample_i      (samples),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .left_wheel_o  (left_wheel_o),
    .right_wheel_o (right_wheel_o),
    .drive_mode_o  (drive_mode_o),
    .speed_scale_o (speed_scale_o)
  );

endmodule
